>>> design/rgb_histogram_with_peak_core_defines.svh
// ----------------------------------------------------------------------------
// rgb_histogram_with_peak_core assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_HISTOGRAM_WITH_PEAK_CORE_DEFINES_SVH
`define RGB_HISTOGRAM_WITH_PEAK_CORE_DEFINES_SVH

// same-cycle implication
`define RHP_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define RHP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/rhp_pkg.sv
// ----------------------------------------------------------------------------
// rhp_pkg
// Constants, codes and controller/datapath link types of the RGB histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhp_pkg;

  localparam int BIN_COUNT  = 256;
  localparam int COUNT_BITS = 24;
  localparam int FIELD_W    = 8;
  localparam int OP_W       = 2;
  localparam int CH_W       = 3;

  localparam logic [CH_W-1:0] CH_EN_RESET = 3'd7;

  typedef enum logic [OP_W-1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_RD
  } state_t;

  typedef struct packed {
    logic capture;
    logic sel_bin;
    logic clr_start;
    logic clr_wr;
    logic acc_wr;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

endpackage

>>> design/rhp_in_if.sv
// ----------------------------------------------------------------------------
// rhp_in_if
// Input item channel: valid/ready with op and pixel/bin fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rhp_in_if;
  logic                          valid;
  logic                          ready;
  logic [rhp_pkg::OP_W-1:0]      op;
  logic [rhp_pkg::FIELD_W-1:0]   red;
  logic [rhp_pkg::FIELD_W-1:0]   green;
  logic [rhp_pkg::FIELD_W-1:0]   blue;
  logic [rhp_pkg::FIELD_W-1:0]   bin;

  modport source (output valid, op, red, green, blue, bin, input ready);
  modport sink   (input valid, op, red, green, blue, bin, output ready);
endinterface

>>> design/rhp_out_if.sv
// ----------------------------------------------------------------------------
// rhp_out_if
// Result item channel: valid/ready with three bin counts and the peak.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rhp_out_if #(
  parameter int COUNT_BITS = rhp_pkg::COUNT_BITS
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] red_count;
  logic [COUNT_BITS-1:0] green_count;
  logic [COUNT_BITS-1:0] blue_count;
  logic [COUNT_BITS-1:0] peak_count;

  modport source (output valid, red_count, green_count, blue_count, peak_count,
                  input ready);
  modport sink   (input valid, red_count, green_count, blue_count, peak_count,
                  output ready);
endinterface

>>> design/rhp_ram.sv
// ----------------------------------------------------------------------------
// rhp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhp_ram #(
  parameter int WIDTH = rhp_pkg::COUNT_BITS,
  parameter int DEPTH = rhp_pkg::BIN_COUNT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/rhp_ctrl.sv
// ----------------------------------------------------------------------------
// rhp_ctrl
// Sequencer: clearing sweep, read-modify-write of a pixel, bin read-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rgb_histogram_with_peak_core_defines.svh"

module rhp_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [rhp_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  rhp_pkg::dp_stat_t        stat,
  output rhp_pkg::dp_cmd_t         cmd
);

  rhp_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  rhp_pkg::op_t    op;

  assign op       = rhp_pkg::op_t'(in_op);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rhp_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_nxt = rhp_pkg::ST_IDLE;
      end
      rhp_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (op)
            rhp_pkg::OP_ACCUM: state_nxt = rhp_pkg::ST_ACC;
            rhp_pkg::OP_READ:  state_nxt = rhp_pkg::ST_RD;
            rhp_pkg::OP_CLEAR: state_nxt = rhp_pkg::ST_CLEAR;
            default:           state_nxt = rhp_pkg::ST_IDLE;
          endcase
        end
      end
      rhp_pkg::ST_ACC: begin
        state_nxt = rhp_pkg::ST_IDLE;
      end
      rhp_pkg::ST_RD: begin
        if (out_free) state_nxt = rhp_pkg::ST_IDLE;
      end
      default: state_nxt = rhp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    cmd.sel_bin   = (op == rhp_pkg::OP_READ);
    unique case (state_r)
      rhp_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      rhp_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.capture   = in_valid;
        cmd.clr_start = in_valid && (op == rhp_pkg::OP_CLEAR);
      end
      rhp_pkg::ST_ACC: begin
        cmd.acc_wr = 1'b1;
      end
      rhp_pkg::ST_RD: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhp_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RHP_ASSERT_NOW(a_no_accept_in_sweep, cmd.clr_wr, !in_ready, "item accepted during clear sweep")
  `RHP_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid, "loaded result not presented")
  `RHP_ASSERT_NEXT(a_acc_one_cycle, state_r == rhp_pkg::ST_ACC, state_r == rhp_pkg::ST_IDLE, "accumulate write overran")
  `RHP_ASSERT_NEXT(a_clear_starts_sweep, cmd.clr_start, state_r == rhp_pkg::ST_CLEAR, "clear item did not start sweep")

endmodule

>>> design/rhp_datapath.sv
// ----------------------------------------------------------------------------
// rhp_datapath
// Count memories, saturating increment, running peaks and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhp_datapath #(
  parameter int BIN_COUNT  = rhp_pkg::BIN_COUNT,
  parameter int COUNT_BITS = rhp_pkg::COUNT_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rhp_pkg::dp_cmd_t            cmd,
  output rhp_pkg::dp_stat_t           stat,
  input  logic [rhp_pkg::FIELD_W-1:0] in_red,
  input  logic [rhp_pkg::FIELD_W-1:0] in_green,
  input  logic [rhp_pkg::FIELD_W-1:0] in_blue,
  input  logic [rhp_pkg::FIELD_W-1:0] in_bin,
  input  logic                        cfg_we,
  input  logic [rhp_pkg::CH_W-1:0]    cfg_wdata,
  output logic [COUNT_BITS-1:0]       red_count,
  output logic [COUNT_BITS-1:0]       green_count,
  output logic [COUNT_BITS-1:0]       blue_count,
  output logic [COUNT_BITS-1:0]       peak_count
);

  localparam int AW = $clog2(BIN_COUNT);
  localparam int NCH = 3;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [AW-1:0] LAST_ADDR = AW'(BIN_COUNT - 1);

  function automatic logic in_range(input logic [rhp_pkg::FIELD_W-1:0] v);
    return 32'(v) < 32'(BIN_COUNT);
  endfunction

  logic [rhp_pkg::FIELD_W-1:0] fld     [NCH];
  logic [AW-1:0]               addr_r  [NCH];
  logic                        ok_r    [NCH];
  logic [AW-1:0]               raddr   [NCH];
  logic [AW-1:0]               waddr   [NCH];
  logic                        we      [NCH];
  logic [COUNT_BITS-1:0]       wdata   [NCH];
  logic [COUNT_BITS-1:0]       rdata   [NCH];
  logic [COUNT_BITS-1:0]       inc     [NCH];
  logic [COUNT_BITS-1:0]       peak_r  [NCH];
  logic [COUNT_BITS-1:0]       cnt_out_r [NCH];
  logic [COUNT_BITS-1:0]       peak_out_r;
  logic [COUNT_BITS-1:0]       pk0, pk1, pk2;
  logic [AW-1:0]               clr_cnt_r;
  logic [rhp_pkg::CH_W-1:0]    ch_en_r;

  assign fld[0] = cmd.sel_bin ? in_bin : in_red;
  assign fld[1] = cmd.sel_bin ? in_bin : in_green;
  assign fld[2] = cmd.sel_bin ? in_bin : in_blue;

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    assign raddr[c] = cmd.capture ? AW'(fld[c]) : addr_r[c];
    assign inc[c]   = (rdata[c] == COUNT_MAX) ? rdata[c] : rdata[c] + COUNT_BITS'(1);
    assign we[c]    = cmd.clr_wr || (cmd.acc_wr && ok_r[c]);
    assign waddr[c] = cmd.clr_wr ? clr_cnt_r : addr_r[c];
    assign wdata[c] = cmd.clr_wr ? '0 : inc[c];

    rhp_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BIN_COUNT)
    ) u_ram (
      .clk   (clk),
      .we    (we[c]),
      .waddr (waddr[c]),
      .wdata (wdata[c]),
      .raddr (raddr[c]),
      .rdata (rdata[c])
    );

    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        addr_r[c] <= AW'(fld[c]);
        ok_r[c]   <= in_range(fld[c]);
      end
      if (cmd.load_out) begin
        cnt_out_r[c] <= ok_r[c] ? rdata[c] : '0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n || cmd.clr_start) begin
        peak_r[c] <= '0;
      end else if (cmd.acc_wr && ok_r[c] && (inc[c] > peak_r[c])) begin
        peak_r[c] <= inc[c];
      end
    end
  end

  assign pk0 = ch_en_r[0] ? peak_r[0] : '0;
  assign pk1 = (ch_en_r[1] && (peak_r[1] > pk0)) ? peak_r[1] : pk0;
  assign pk2 = (ch_en_r[2] && (peak_r[2] > pk1)) ? peak_r[2] : pk1;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      peak_out_r <= pk2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_start) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_en_r <= rhp_pkg::CH_EN_RESET;
    end else if (cfg_we) begin
      ch_en_r <= cfg_wdata;
    end
  end

  assign stat.clr_last = (clr_cnt_r == LAST_ADDR);

  assign red_count   = cnt_out_r[0];
  assign green_count = cnt_out_r[1];
  assign blue_count  = cnt_out_r[2];
  assign peak_count  = peak_out_r;

endmodule

>>> design/rgb_histogram_with_peak_core.sv
// ----------------------------------------------------------------------------
// rgb_histogram_with_peak_core
// Three-channel 256-bin image histogram with per-channel running peak.
// ----------------------------------------------------------------------------
// Accumulate items take a read-modify-write pass through the three count
// memories, which have one write port and a registered read port: the bins
// are read when the item is captured and written back incremented in the
// accumulate state. A read item also waits for the result slot to drain, and
// a clear item zeroes one bin per cycle in a sweep. After reset the same
// clearing sweep runs before the first item is taken; channel_enable writes
// are taken at any time. Op code 3 is consumed with no effect. A finished
// read result waits in an output register while the next item is accepted.
`timescale 1ns / 1ps

module rgb_histogram_with_peak_core #(
  parameter int BIN_COUNT  = rhp_pkg::BIN_COUNT,
  parameter int COUNT_BITS = rhp_pkg::COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  rhp_in_if.sink                   in_if,
  rhp_out_if.source                out_if,
  input  logic                     cfg_we,
  input  logic [rhp_pkg::CH_W-1:0] cfg_wdata
);

  rhp_pkg::dp_cmd_t  cmd;
  rhp_pkg::dp_stat_t stat;

  rhp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_op     (in_if.op),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rhp_datapath #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_red      (in_if.red),
    .in_green    (in_if.green),
    .in_blue     (in_if.blue),
    .in_bin      (in_if.bin),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .red_count   (out_if.red_count),
    .green_count (out_if.green_count),
    .blue_count  (out_if.blue_count),
    .peak_count  (out_if.peak_count)
  );

endmodule
